// ===== src/blide_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blide_pkg
// Shared types and codes for the bounded list with insert, delete and dump.
// ----------------------------------------------------------------------------
package blide_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned INDEX_W = 6;
	localparam int unsigned FUNC_W  = 2;

	// operation codes carried on the request side
	typedef enum logic [FUNC_W-1:0] {
		FN_PUSH_FRONT = 2'd0,
		FN_PUSH_BACK  = 2'd1,
		FN_DELETE     = 2'd2,
		FN_NOP        = 2'd3
	} func_t;

	// one result of a dump
	typedef struct packed {
		logic [VALUE_W-1:0] item_value;
		logic               last;
		logic               list_empty;
		logic               dropped;
	} out_item_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_SHIFT = 5'b00100,
		ST_FIN   = 5'b01000,
		ST_DUMP  = 5'b10000
	} state_t;

endpackage : blide_pkg
`default_nettype wire

// ===== src/bounded_list_insert_delete_dump.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_list_insert_delete_dump
// Circular list of up to CAPACITY signed words with front/back insert,
// indexed delete and a full front-to-back dump after every request.
// ----------------------------------------------------------------------------
// channel  dir  tdata                         tuser                  tlast
// s_*      in   value[31:0] index[37:32]      func[1:0]              -
// m_*      out  item_value[31:0]              list_empty[0] drop[1]  last
//
// A request is decoded and applied in EXEC; a delete then shifts the tail
// forward one place through the RAM (SHIFT, FIN). The dump reads one item
// per cycle while the result queue has room (an empty list gives one
// marker); the single RAM read port sets this rate. Reset clears the front
// pointer and count with no clearing pass. A stalled output holds the dump;
// a new request is taken once the previous dump has issued its last read.
// ----------------------------------------------------------------------------
module bounded_list_insert_delete_dump
	import blide_pkg::*;
#(
	parameter int unsigned CAPACITY = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // value[31:0], index[37:32], zero pad
	input  wire logic [1:0]  s_tuser,   // func[1:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,   // item_value[31:0]
	output logic [1:0]       m_tuser,   // list_empty[0], dropped[1]
	output logic             m_tlast
);

	localparam int unsigned PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
	localparam logic [PTR_W:0]   CAP_S  = (PTR_W+1)'(CAPACITY);
	localparam logic [PTR_W-1:0] CAP_M1 = PTR_W'(CAPACITY - 1);
	localparam logic [CNT_W-1:0] CAP_C  = CNT_W'(CAPACITY);

	state_t               state_q;
	logic [PTR_W-1:0]     front_q;
	logic [CNT_W-1:0]     count_q;
	logic [CNT_W-1:0]     k_q;
	func_t                func_q;
	logic [VALUE_W-1:0]   value_q;
	logic [INDEX_W-1:0]   index_q;
	logic                 drop_q;

	logic                 wr_pend_s1;
	logic [PTR_W-1:0]     wr_slot_s1;
	logic                 rd_pend_s1;
	logic                 rd_last_s1;

	logic                 ram_we;
	logic [PTR_W-1:0]     ram_waddr;
	logic [VALUE_W-1:0]   ram_wdata;
	logic                 ram_re;
	logic [PTR_W-1:0]     ram_raddr;
	logic [VALUE_W-1:0]   ram_rdata;

	logic                 q_push;
	out_item_t            q_item;
	logic                 q_valid;
	out_item_t            q_head;
	logic [1:0]           q_occ;
	logic                 q_pop;
	logic [1:0]           q_load;
	logic                 q_room;

	logic                 in_acc;
	logic                 is_full;
	logic                 del_ok;
	logic                 del_shift;
	logic [PTR_W-1:0]     front_dec;
	logic [PTR_W-1:0]     slot_k;
	logic [PTR_W-1:0]     slot_k1;
	logic [PTR_W-1:0]     slot_cnt;
	logic                 shift_done;
	logic                 dump_last;

	// physical slot of a list position
	function automatic logic [PTR_W-1:0] slot_of(
		input logic [PTR_W-1:0] front,
		input logic [CNT_W-1:0] pos
	);
		logic [PTR_W:0] s;
		s = {1'b0, front} + (PTR_W+1)'(pos);
		if (s >= CAP_S) begin
			s = s - CAP_S;
		end
		return s[PTR_W-1:0];
	endfunction

	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid && s_tready;

	// request decode
	assign is_full   = (count_q == CAP_C);
	assign del_ok    = ({1'b0, index_q} < 7'(count_q));
	assign del_shift = (({1'b0, index_q} + 7'd1) < 7'(count_q));
	assign front_dec = (front_q == '0) ? CAP_M1 : (front_q - PTR_W'(1));
	assign slot_k    = slot_of(front_q, k_q);
	assign slot_k1   = slot_of(front_q, k_q + CNT_W'(1));
	assign slot_cnt  = slot_of(front_q, count_q);
	assign shift_done = (({1'b0, k_q} + (CNT_W+1)'(2)) == {1'b0, count_q});
	assign dump_last  = (({1'b0, k_q} + (CNT_W+1)'(1)) == {1'b0, count_q});

	// room in the result queue for one more read in flight
	assign q_pop  = q_valid && m_tready;
	assign q_load = q_occ - {1'b0, q_pop} + {1'b0, rd_pend_s1};
	assign q_room = (q_load < 2'd2);

	// RAM port control
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wr_slot_s1;
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = slot_k;
		if (wr_pend_s1) begin
			ram_we = 1'b1;
		end else if ((state_q == ST_EXEC) && !is_full) begin
			if (func_q == FN_PUSH_FRONT) begin
				ram_we    = 1'b1;
				ram_waddr = front_dec;
				ram_wdata = value_q;
			end else if (func_q == FN_PUSH_BACK) begin
				ram_we    = 1'b1;
				ram_waddr = slot_cnt;
				ram_wdata = value_q;
			end
		end
		if (state_q == ST_SHIFT) begin
			ram_re    = 1'b1;
			ram_raddr = slot_k1;
		end else if ((state_q == ST_DUMP) && q_room && (count_q != '0)) begin
			ram_re = 1'b1;
		end
	end

	// sequencer and list bookkeeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			front_q    <= '0;
			count_q    <= '0;
			k_q        <= '0;
			drop_q     <= 1'b0;
			wr_pend_s1 <= 1'b0;
			rd_pend_s1 <= 1'b0;
		end else begin
			wr_pend_s1 <= (state_q == ST_SHIFT);
			rd_pend_s1 <= ram_re && (state_q == ST_DUMP);
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					drop_q  <= 1'b0;
					k_q     <= '0;
					state_q <= ST_DUMP;
					if ((func_q == FN_PUSH_FRONT) || (func_q == FN_PUSH_BACK)) begin
						if (is_full) begin
							drop_q <= 1'b1;
						end else begin
							count_q <= count_q + CNT_W'(1);
							if (func_q == FN_PUSH_FRONT) begin
								front_q <= front_dec;
							end
						end
					end else if ((func_q == FN_DELETE) && del_ok) begin
						if (del_shift) begin
							k_q     <= CNT_W'(index_q);
							state_q <= ST_SHIFT;
						end else begin
							count_q <= count_q - CNT_W'(1);
						end
					end
				end
				ST_SHIFT: begin
					k_q <= k_q + CNT_W'(1);
					if (shift_done) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					count_q <= count_q - CNT_W'(1);
					k_q     <= '0;
					state_q <= ST_DUMP;
				end
				ST_DUMP: begin
					if (q_room) begin
						if ((count_q == '0) || dump_last) begin
							state_q <= ST_IDLE;
						end else begin
							k_q <= k_q + CNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request and pipeline payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			func_q  <= func_t'(s_tuser);
			value_q <= s_tdata[31:0];
			index_q <= s_tdata[37:32];
		end
		wr_slot_s1 <= slot_k;
		rd_last_s1 <= dump_last;
	end

	// list store
	blide_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// result assembly: read data or the single empty marker
	always_comb begin
		q_push = 1'b0;
		q_item = '{item_value: ram_rdata, last: rd_last_s1, list_empty: 1'b0,
			dropped: drop_q};
		if (rd_pend_s1) begin
			q_push = 1'b1;
		end else if ((state_q == ST_DUMP) && q_room && (count_q == '0)) begin
			q_push = 1'b1;
			q_item = '{item_value: '0, last: 1'b1, list_empty: 1'b1, dropped: drop_q};
		end
	end

	blide_outq u_outq (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_head),
		.occupancy  (q_occ)
	);

	assign m_tvalid = q_valid;
	assign m_tdata  = q_head.item_value;
	assign m_tlast  = q_head.last;
	assign m_tuser  = {q_head.dropped, q_head.list_empty};

	// count never exceeds the capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("entry count above capacity");

	// front pointer stays inside the store
	a_front_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, front_q} < CAP_S)
		else $error("front pointer out of range");

	// no shift write is left over when a new request can be taken
	a_idle_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !wr_pend_s1)
		else $error("shift write pending while idle");

	// read data only arrives for a read issued by the dump
	a_read_origin: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> $past(state_q == ST_DUMP))
		else $error("read data without a dump read");

endmodule : bounded_list_insert_delete_dump
`default_nettype wire

// ===== src/blide_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blide_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module blide_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule : blide_ram
`default_nettype wire

// ===== src/blide_outq.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blide_outq
// Two-entry result queue that decouples the dump reads from the output stall.
// ----------------------------------------------------------------------------
module blide_outq
	import blide_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      push,
	input  wire out_item_t push_item,
	input  wire logic      pop,
	output logic           head_valid,
	output out_item_t      head_item,
	output logic [1:0]     occupancy
);

	out_item_t  slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;

	assign head_valid = (cnt_q != 2'd0);
	assign head_item  = slot_q[rd_ptr_q];
	assign occupancy  = cnt_q;

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_item;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

	// never written when full without a pop in the same cycle
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && !pop && (cnt_q == 2'd2)))
		else $error("result queue overflow");

	// never popped when empty
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (cnt_q != 2'd0))
		else $error("result queue underflow");

	// fill level stays within two entries
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3)
		else $error("result queue count out of range");

endmodule : blide_outq
`default_nettype wire
